FILE: rtl/srmq_pkg.sv
// Package with shared types and constants for the send/receive match queue.
`default_nettype none
package srmq_pkg;
    localparam int unsigned KEY_W  = 36;
    localparam int unsigned LEN_W  = 32;
    localparam int unsigned TIME_W = 64;
    localparam int unsigned ENTRY_W = KEY_W + LEN_W + TIME_W;

    localparam logic ACT_SEND = 1'b0;
    localparam logic ACT_RECV = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [LEN_W-1:0]  len;
        logic [TIME_W-1:0] tim;
    } entry_t;
endpackage
`default_nettype wire

FILE: rtl/srmq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module srmq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/send_receive_match_queue_unit.sv
// Top level of the send/receive match queue: sequencer, counts and entry stores.
// A result follows each accepted transaction, hit or miss: a scan reads and compares
// each pending entry of the searched store in turn, and on a hit a compaction reads
// each later entry and writes it one slot down. Busy stays high until the sequencer
// is idle again, so a new transaction waits for the last. The receiver cannot stall.
// Reset clears counts, the size-check register and the sequencer, not the entry stores.
`default_nettype none
module send_receive_match_queue_unit
    import srmq_pkg::*;
#(
    parameter int unsigned NUM_RANKS  = 16,
    parameter int unsigned PEND_DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    input  wire logic        action,
    input  wire logic [3:0]  src_rank,
    input  wire logic [3:0]  dst_rank,
    input  wire logic [31:0] msg_tag,
    input  wire logic [31:0] msg_length,
    input  wire logic [63:0] event_time,
    output logic             result_valid,
    output logic             matched,
    output logic             stored,
    output logic             store_full,
    output logic [63:0]      partner_time
);
    localparam int unsigned RANK_W  = (NUM_RANKS > 1) ? $clog2(NUM_RANKS) : 1;
    localparam int unsigned CNT_W   = $clog2(PEND_DEPTH + 1);
    localparam int unsigned ADDR_W  = $clog2(NUM_RANKS * PEND_DEPTH);
    localparam int unsigned DEPTH   = NUM_RANKS * PEND_DEPTH;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_CMP   = 3'd2;
    localparam logic [2:0] ST_SHRD  = 3'd3;
    localparam logic [2:0] ST_SHWR  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic                enf_reg;
    logic [CNT_W-1:0]    cnt_send_reg [NUM_RANKS];
    logic [CNT_W-1:0]    cnt_recv_reg [NUM_RANKS];

    // Captured transaction.
    logic                act_reg;
    logic [RANK_W-1:0]   src_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [TIME_W-1:0]   tim_reg;

    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    n_reg;
    logic                res_m_reg, res_s_reg, res_f_reg, res_v_reg;
    logic [TIME_W-1:0]   res_t_reg;

    // RAM ports: u_send stores pending sends, u_recv pending receives.
    logic                we_s, we_r;
    logic [ADDR_W-1:0]   waddr, raddr;
    entry_t              wdata, rd_s, rd_r, rd_f;
    logic [ENTRY_W-1:0]  rdw_s, rdw_r;

    srmq_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_send (
        .clk(clk), .we(we_s), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdw_s));
    srmq_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_recv (
        .clk(clk), .we(we_r), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdw_r));

    assign rd_s = entry_t'(rdw_s);
    assign rd_r = entry_t'(rdw_r);
    // A receive searches the sends and a send the receives.
    assign rd_f = (act_reg == ACT_RECV) ? rd_s : rd_r;

    logic [CNT_W-1:0] own_cnt;
    logic             hit;
    logic             accept;

    assign accept  = start && !busy;
    assign busy    = (state_reg != ST_IDLE);
    assign own_cnt = (act_reg == ACT_RECV) ? cnt_recv_reg[src_reg] : cnt_send_reg[src_reg];
    // The single shared comparator.
    assign hit = (rd_f.key == key_reg) && (!enf_reg || rd_f.len == len_reg);

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [RANK_W-1:0] r,
                                                    input logic [CNT_W-1:0] i);
        logic [ADDR_W+CNT_W-1:0] a;
        a = (ADDR_W+CNT_W)'(r) * (ADDR_W+CNT_W)'(PEND_DEPTH) + (ADDR_W+CNT_W)'(i);
        return a[ADDR_W-1:0];
    endfunction

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        we_s       = 1'b0;
        we_r       = 1'b0;
        raddr      = slot_addr(src_reg, idx_reg);
        waddr      = slot_addr(src_reg, idx_reg);
        wdata      = '{key: key_reg, len: len_reg, tim: tim_reg};
        case (state_reg)
            ST_IDLE:
            begin
            end
            ST_SCAN:
            begin
                // Read issued at idx; compare in the next cycle.
                if (idx_reg >= n_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (hit)
                begin
                    state_next = ST_SHRD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SHRD:
            begin
                raddr = slot_addr(src_reg, idx_reg + 1'b1);
                if (idx_reg + 1'b1 >= n_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SHWR;
                end
            end
            ST_SHWR:
            begin
                wdata = rd_f;
                if (act_reg == ACT_RECV)
                begin
                    we_s = 1'b1;
                end
                else
                begin
                    we_r = 1'b1;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = ST_SHRD;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
                waddr      = slot_addr(src_reg, own_cnt);
                if (!res_m_reg && own_cnt < CNT_W'(PEND_DEPTH))
                begin
                    if (act_reg == ACT_RECV)
                    begin
                        we_r = 1'b1;
                    end
                    else
                    begin
                        we_s = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= action;
            src_reg <= RANK_W'(src_rank);
            key_reg <= {dst_rank, msg_tag};
            len_reg <= msg_length;
            tim_reg <= event_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            enf_reg   <= 1'b0;
            idx_reg   <= '0;
            n_reg     <= '0;
            res_v_reg <= 1'b0;
            res_m_reg <= 1'b0;
            res_s_reg <= 1'b0;
            res_f_reg <= 1'b0;
            res_t_reg <= '0;
            for (int r = 0; r < NUM_RANKS; r++)
            begin
                cnt_send_reg[r] <= '0;
                cnt_recv_reg[r] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            res_v_reg <= 1'b0;
            if (cfg_we)
            begin
                enf_reg <= cfg_wdata;
            end
            if (accept)
            begin
                res_m_reg <= 1'b0;
                res_s_reg <= 1'b0;
                res_f_reg <= 1'b0;
                res_t_reg <= '0;
                idx_reg   <= '0;
                if ({5'b0, src_rank} >= 9'(NUM_RANKS))
                begin
                    // Out-of-range rank: an all-zero result, no state change.
                    res_v_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                else
                begin
                    n_reg <= (action == ACT_RECV) ? cnt_send_reg[RANK_W'(src_rank)]
                                                   : cnt_recv_reg[RANK_W'(src_rank)];
                    state_reg <= ST_SCAN;
                end
            end
            if (state_reg == ST_CMP && hit)
            begin
                res_m_reg <= 1'b1;
                res_t_reg <= rd_f.tim;
                if (act_reg == ACT_RECV)
                begin
                    cnt_send_reg[src_reg] <= n_reg - 1'b1;
                end
                else
                begin
                    cnt_recv_reg[src_reg] <= n_reg - 1'b1;
                end
            end
            if (state_reg == ST_DONE)
            begin
                res_v_reg <= 1'b1;
                if (!res_m_reg)
                begin
                    if (own_cnt < CNT_W'(PEND_DEPTH))
                    begin
                        res_s_reg <= 1'b1;
                        if (act_reg == ACT_RECV)
                        begin
                            cnt_recv_reg[src_reg] <= own_cnt + 1'b1;
                        end
                        else
                        begin
                            cnt_send_reg[src_reg] <= own_cnt + 1'b1;
                        end
                    end
                    else
                    begin
                        res_f_reg <= 1'b1;
                    end
                end
            end
        end
    end

    assign result_valid = res_v_reg;
    assign matched      = res_m_reg;
    assign stored       = res_s_reg;
    assign store_full   = res_f_reg;
    assign partner_time = res_t_reg;
endmodule
`default_nettype wire
